[sv/longest_match_token_lexer_assert.svh]
// Assertion helpers shared by the lexer modules.
`ifndef LONGEST_MATCH_TOKEN_LEXER_ASSERT_SVH
`define LONGEST_MATCH_TOKEN_LEXER_ASSERT_SVH
`ifndef SYNTHESIS
`define LML_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define LML_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LML_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define LML_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[sv/lml_pkg.sv]
package lml_pkg;

   localparam int WINDOW_BYTES_DEF = 5;
   localparam int DICT_ENTRIES     = 35;
   localparam int LEX_MAX          = 5;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic [2:0] {
      KIND_QUALITY,
      KIND_EXTENSION,
      KIND_ALTERATION,
      KIND_SUSPENSION,
      KIND_ADD,
      KIND_UNKNOWN
   } kind_type;

   typedef struct packed {
      logic [2:0]           len;
      logic [LEX_MAX*8-1:0] text;
      kind_type             kind;
      logic [4:0]           canon;
   } entry_type;

   typedef struct packed {
      kind_type   kind;
      logic [5:0] entry;
      logic [4:0] canon;
      logic [2:0] len;
      logic [7:0] raw;
   } token_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } q_item_type;

   // The spelling is given most significant byte first; byte 0 of the
   // lexeme ends up in the low byte of the text field.
   function automatic entry_type mk(input logic [2:0] len, input logic [39:0] txt,
                                    input kind_type kind, input logic [4:0] canon);
      entry_type e;
      e.len   = len;
      e.kind  = kind;
      e.canon = canon;
      e.text  = '0;
      for (int k = 0; k < LEX_MAX; k++) begin
         if (k < int'(len)) begin
            e.text[8*k +: 8] = txt[8*(int'(len)-1-k) +: 8];
         end
      end
      return e;
   endfunction

   localparam entry_type DICT [DICT_ENTRIES] = '{
      mk(3'd5, 40'("major"), KIND_QUALITY, 5'd0),
      mk(3'd3, 40'("maj"), KIND_QUALITY, 5'd0),
      mk(3'd5, 40'("minor"), KIND_QUALITY, 5'd1),
      mk(3'd3, 40'("min"), KIND_QUALITY, 5'd1),
      mk(3'd1, 40'("m"), KIND_QUALITY, 5'd1),
      mk(3'd3, 40'("dim"), KIND_QUALITY, 5'd2),
      mk(3'd2, 40'h00_0000_C2B0, KIND_QUALITY, 5'd2),
      mk(3'd3, 40'("aug"), KIND_QUALITY, 5'd3),
      mk(3'd1, 40'("+"), KIND_QUALITY, 5'd3),
      mk(3'd5, 40'("maj13"), KIND_EXTENSION, 5'd4),
      mk(3'd2, 40'("13"), KIND_EXTENSION, 5'd5),
      mk(3'd5, 40'("maj11"), KIND_EXTENSION, 5'd6),
      mk(3'd2, 40'("11"), KIND_EXTENSION, 5'd7),
      mk(3'd4, 40'("maj9"), KIND_EXTENSION, 5'd8),
      mk(3'd1, 40'("9"), KIND_EXTENSION, 5'd9),
      mk(3'd4, 40'("maj7"), KIND_EXTENSION, 5'd10),
      mk(3'd2, 40'("7M"), KIND_EXTENSION, 5'd10),
      mk(3'd2, 40'("M7"), KIND_EXTENSION, 5'd10),
      mk(3'd2, 40'h00_0000_CE94, KIND_EXTENSION, 5'd10),
      mk(3'd3, 40'h00_00CE_9437, KIND_EXTENSION, 5'd10),
      mk(3'd4, 40'h00_E296_B337, KIND_EXTENSION, 5'd10),
      mk(3'd3, 40'h00_00E2_96B3, KIND_EXTENSION, 5'd10),
      mk(3'd1, 40'("7"), KIND_EXTENSION, 5'd11),
      mk(3'd1, 40'("6"), KIND_EXTENSION, 5'd12),
      mk(3'd3, 40'("#11"), KIND_ALTERATION, 5'd13),
      mk(3'd3, 40'("b13"), KIND_ALTERATION, 5'd14),
      mk(3'd2, 40'("#9"), KIND_ALTERATION, 5'd15),
      mk(3'd2, 40'("b9"), KIND_ALTERATION, 5'd16),
      mk(3'd2, 40'("#5"), KIND_ALTERATION, 5'd17),
      mk(3'd2, 40'("b5"), KIND_ALTERATION, 5'd18),
      mk(3'd4, 40'("sus4"), KIND_SUSPENSION, 5'd19),
      mk(3'd4, 40'("sus2"), KIND_SUSPENSION, 5'd20),
      mk(3'd5, 40'("add13"), KIND_ADD, 5'd21),
      mk(3'd5, 40'("add11"), KIND_ADD, 5'd22),
      mk(3'd4, 40'("add9"), KIND_ADD, 5'd23)
   };

endpackage

[sv/lml_channels.sv]
interface lml_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       string_end;

   modport source (output valid, output byte_in, output string_end, input ready);
   modport sink (input valid, input byte_in, input string_end, output ready);
endinterface

interface lml_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_kind;
   logic [5:0] entry_index;
   logic [4:0] canonical_index;
   logic [2:0] token_length;
   logic [7:0] raw_byte;
   logic       run_last;
   logic       token_is_final;

   modport source (output valid, output token_kind, output entry_index,
                   output canonical_index, output token_length, output raw_byte,
                   output run_last, output token_is_final, input ready);
   modport sink (input valid, input token_kind, input entry_index,
                 input canonical_index, input token_length, input raw_byte,
                 input run_last, input token_is_final, output ready);
endinterface

[sv/lml_front.sv]
`include "longest_match_token_lexer_assert.svh"

module lml_front (
   input  logic                clock,
   input  logic                reset,
   lml_req_if.sink             req_ch,
   output logic                q_valid,
   output lml_pkg::q_item_type q_item,
   input  logic                q_ready
);
   import lml_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   q_item_type       mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign req_ch.ready = (count_ff != CW'(DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != '0);
   assign q_item       = mem_ff[rd_ptr_ff];
   assign pop          = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff].data <= req_ch.byte_in;
         mem_ff[wr_ptr_ff].last <= req_ch.string_end;
      end
   end

   `LML_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "queue overfilled")
   `LML_ASSERT_NEXT(a_count_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")
   `LML_ASSERT_IMPLY(a_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "empty queue with unequal pointers")

endmodule

[sv/lml_match.sv]
module lml_match (
   input  logic [lml_pkg::LEX_MAX-1:0][7:0] window,
   input  logic [2:0]                       avail,
   output lml_pkg::token_type               token
);
   import lml_pkg::*;

   logic [LEX_MAX:1]       found;
   logic [LEX_MAX:1][5:0]  idx;
   logic [5:0]             best;
   logic [2:0]             best_len;

   // At most one entry of each length can match, so the per-length index
   // is a plain OR of the hitting entries.
   always_comb begin
      logic entry_hit;
      found = '0;
      idx   = '0;
      for (int i = 0; i < DICT_ENTRIES; i++) begin
         entry_hit = (DICT[i].len <= avail);
         for (int k = 0; k < LEX_MAX; k++) begin
            if (3'(k) < DICT[i].len && window[k] != DICT[i].text[8*k +: 8]) begin
               entry_hit = 1'b0;
            end
         end
         for (int l = 1; l <= LEX_MAX; l++) begin
            if (entry_hit && DICT[i].len == 3'(l)) begin
               found[l] = 1'b1;
               idx[l]   = idx[l] | 6'(i);
            end
         end
      end
      best_len = '0;
      best     = '0;
      for (int l = 1; l <= LEX_MAX; l++) begin
         if (found[l]) begin
            best_len = 3'(l);
            best     = idx[l];
         end
      end
   end

   always_comb begin
      token.raw = window[0];
      if (best_len == '0) begin
         token.kind  = KIND_UNKNOWN;
         token.entry = '0;
         token.canon = '0;
         token.len   = 3'd1;
      end else begin
         token.kind  = DICT[best].kind;
         token.entry = best;
         token.canon = DICT[best].canon;
         token.len   = best_len;
      end
   end

endmodule

[sv/lml_back.sv]
`include "longest_match_token_lexer_assert.svh"

module lml_back #(
   parameter int WINDOW_BYTES = lml_pkg::WINDOW_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  lml_pkg::q_item_type q_item,
   output logic                q_ready,
   lml_rsp_if.source           rsp_ch
);
   import lml_pkg::*;

   localparam int W  = WINDOW_BYTES;
   localparam int FW = $clog2(W + 1);

   typedef enum logic {
      MODE_STREAM,
      MODE_FLUSH
   } mode_type;

   mode_type              mode_ff;
   logic [W-1:0][7:0]     win_ff;
   logic [FW-1:0]         fill_ff;
   logic                  rsp_valid_ff;
   token_type             tok_ff;
   logic                  run_last_ff;
   logic                  final_ff;

   logic [W-1:0][7:0]     app_win, cur_win, sh_win;
   logic [FW-1:0]         app_fill, cur_fill, rem_fill;
   logic [2:0]            avail;
   token_type             tok;
   logic                  out_free, pop, emit, ends, done;

   // The incoming byte is placed into the window and matched in the same
   // cycle, so a plain byte that fills the window yields its token at once.
   always_comb begin
      for (int i = 0; i < W; i++) begin
         app_win[i] = (FW'(i) == fill_ff) ? q_item.data : win_ff[i];
      end
   end

   assign app_fill = fill_ff + 1'b1;
   assign cur_win  = (mode_ff == MODE_FLUSH) ? win_ff : app_win;
   assign cur_fill = (mode_ff == MODE_FLUSH) ? fill_ff : app_fill;
   assign avail    = (cur_fill > FW'(LEX_MAX)) ? 3'(LEX_MAX) : 3'(cur_fill);

   lml_match u_match (
      .window (cur_win[LEX_MAX-1:0]),
      .avail  (avail),
      .token  (tok)
   );

   always_comb begin
      int src;
      for (int i = 0; i < W; i++) begin
         sh_win[i] = '0;
         for (int l = 1; l <= LEX_MAX; l++) begin
            src = i + l;
            if (tok.len == 3'(l) && src < W) begin
               sh_win[i] = cur_win[src];
            end
         end
      end
   end

   assign rem_fill = cur_fill - FW'(tok.len);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign q_ready = (mode_ff == MODE_STREAM) &&
                    (out_free || (!q_item.last && app_fill != FW'(W)));
   assign pop     = q_valid && q_ready;
   assign emit    = (mode_ff == MODE_FLUSH) ? out_free :
                    (pop && (q_item.last || app_fill == FW'(W)));
   assign ends    = (mode_ff == MODE_FLUSH) || q_item.last;
   assign done    = ends && (rem_fill == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STREAM;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            fill_ff      <= done ? '0 : rem_fill;
            mode_ff      <= (ends && !done) ? MODE_FLUSH : MODE_STREAM;
            win_ff       <= done ? '0 : sh_win;
            tok_ff       <= tok;
            run_last_ff  <= !ends || done;
            final_ff     <= done;
         end else begin
            if (rsp_ch.ready) begin
               rsp_valid_ff <= 1'b0;
            end
            if (pop) begin
               fill_ff <= app_fill;
               win_ff  <= app_win;
            end
         end
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.token_kind      = tok_ff.kind;
   assign rsp_ch.entry_index     = tok_ff.entry;
   assign rsp_ch.canonical_index = tok_ff.canon;
   assign rsp_ch.token_length    = tok_ff.len;
   assign rsp_ch.raw_byte        = tok_ff.raw;
   assign rsp_ch.run_last        = run_last_ff;
   assign rsp_ch.token_is_final  = final_ff;

   `LML_ASSERT_IMPLY(a_fill_below_window, clock, reset,
      1'b1, fill_ff < FW'(W), "window fill reached its depth between items")
   `LML_ASSERT_IMPLY(a_flush_nonempty, clock, reset,
      mode_ff == MODE_FLUSH, fill_ff != '0, "flushing an empty window")
   `LML_ASSERT_IMPLY(a_final_is_last, clock, reset,
      rsp_valid_ff && final_ff, run_last_ff, "final token not marked last of its run")
   `LML_ASSERT_IMPLY(a_flush_ends_empty, clock, reset,
      $fell(mode_ff == MODE_FLUSH), fill_ff == '0, "flush left bytes behind")

endmodule

[sv/longest_match_token_lexer.sv]
// Bytes accepted on req pass through the queue; a token is registered for rsp
// when a byte fills the window or ends a string. Throughput: one byte per cycle
// while strings continue and rsp takes tokens; a byte with string_end holds the
// token stage while the window flushes, with a two-entry queue absorbing input.
// Reset is synchronous and active high: it empties the queue and the window and
// drops any pending token.
module longest_match_token_lexer #(
   parameter int WINDOW_BYTES = lml_pkg::WINDOW_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lml_req_if.sink   req_ch,
   lml_rsp_if.source rsp_ch
);
   import lml_pkg::*;

   logic       q_valid;
   logic       q_ready;
   q_item_type q_item;

   lml_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_ready (q_ready)
   );

   lml_back #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_ready (q_ready),
      .rsp_ch  (rsp_ch)
   );

endmodule
